>>> design/ppmre_pkg.sv
// ----------------------------------------------------------------------------
// PPM range encoder package
// Shared widths, memory layout constants, command codes and the context key.
// ----------------------------------------------------------------------------
package ppmre_pkg;

   localparam int MAX_ORDER   = 4;
   localparam int CTX_ENTRIES = 256;
   localparam int CTX_IW      = 8;    // context entry index bits
   localparam int SYM_W       = 8;
   localparam int CNT_W       = 16;
   localparam int TOT_W       = 24;
   localparam int KEY_W       = 35;
   localparam int CTX_DW      = KEY_W + TOT_W;
   localparam int ROW_W       = CTX_IW + 1;
   localparam int CNT_AW      = ROW_W + SYM_W;
   localparam int CNT_DEPTH   = (CTX_ENTRIES + 1) * 256;
   localparam int ORD_W       = 3;
   localparam int ORD_IW      = 2;
   localparam int RNG_W       = 32;

   localparam logic [ROW_W-1:0] BASE_ROW  = ROW_W'(CTX_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [TOT_W-1:0] BASE_INIT = TOT_W'(256);

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_FINISH = 1'b1
   } command_type;

   // Key layout: order in the top three bits, history byte i in bits 8i+7..8i.
   function automatic logic [KEY_W-1:0] ctx_key(input logic [ORD_W-1:0] ord,
                                                input logic [31:0] hist);
      logic [KEY_W-1:0] key;
      key = {ord, 32'h0};
      for (int i = 0; i < 4; i++) begin
         if (i < int'(ord)) begin
            key[8*i +: 8] = hist[8*i +: 8];
         end
      end
      return key;
   endfunction

endpackage

>>> design/ppmre_div.sv
// ----------------------------------------------------------------------------
// PPM range encoder divider
// Restoring divider, one quotient bit per cycle; gives range / total.
// ----------------------------------------------------------------------------
module ppmre_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ppmre_pkg::RNG_W-1:0]   dividend,
   input  logic [ppmre_pkg::TOT_W-1:0]   divisor,
   output logic                          done,
   output logic [ppmre_pkg::RNG_W-1:0]   quotient
);
   import ppmre_pkg::*;

   logic [RNG_W-1:0] quot_ff, quot_in;
   logic [TOT_W-1:0] rem_ff, rem_in;
   logic [TOT_W-1:0] dvs_ff, dvs_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [TOT_W:0]   trial;
   logic [TOT_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quot_ff[RNG_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 6'(RNG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[TOT_W]) begin
            rem_in  = diff[TOT_W-1:0];
            quot_in = {quot_ff[RNG_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[TOT_W-1:0];
            quot_in = {quot_ff[RNG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> design/ppmre_top_dummy_placeholder.sv
// ----------------------------------------------------------------------------
// PPM range encoder output stage
// Holds one result byte until the consumer takes it.
// ----------------------------------------------------------------------------
module ppmre_out (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [7:0] load_byte,
   input  logic       load_last,
   output logic       free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   always_comb begin
      free     = !valid_ff || rsp_ready;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = load_byte;
         last_in  = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

>>> design/ppm_range_encoder_top.sv
// ----------------------------------------------------------------------------
// PPM range encoder top level
// Context-model (orders four to one, then order zero) byte encoder with a
// 32-bit range coder; counts and context entries live in two memories.
// ----------------------------------------------------------------------------
// Encode flow: the contexts in use are scanned one per cycle; each coding step runs the bit-serial
// divider, and a step that codes the symbol first sweeps the cumulative count up to the symbol
// value; each context created has its 256-count row cleared, each found context is updated,
// orders with no context are skipped, and bytes out can stall on the consumer.
// Transactions: one at a time, the next accepted on return to idle.
// Reset: synchronous, active high; no clearing pass, order-zero counts use valid bits.
// ----------------------------------------------------------------------------
module ppm_range_encoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);
   import ppmre_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FLUSH, ST_SCAN, ST_ORD_CHK, ST_ORD_RD, ST_BASE_RD, ST_SUM,
      ST_DIV_GO, ST_DIV_WAIT, ST_MUL, ST_REN1, ST_REN2, ST_UPD_BASE_RD,
      ST_UPD_BASE_WR, ST_UPD_ORD, ST_UPD_WR, ST_CLR, ST_FIN
   } state_type;

   // The count memory holds one 256-entry row per context entry, with the
   // order-zero model in the last row. The context memory holds key and total.
   logic [CNT_W-1:0]  cnt_mem [CNT_DEPTH];
   logic [CTX_DW-1:0] ctx_mem [CTX_ENTRIES];

   logic              cnt_we, ctx_we;
   logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]  cnt_wdata;
   logic [CTX_IW-1:0] ctx_waddr, ctx_raddr;
   logic [CTX_DW-1:0] ctx_wdata;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic [CTX_DW-1:0] ctx_rd_ff;

   state_type                    state_ff, state_in;
   logic [RNG_W-1:0]             low_ff, low_in;
   logic [RNG_W-1:0]             range_ff, range_in;
   logic [31:0]                  hist_ff, hist_in;
   logic [ORD_W-1:0]             seen_ff, seen_in;
   logic [255:0]                 base_vld_ff, base_vld_in;
   logic [TOT_W-1:0]             base_tot_ff, base_tot_in;
   logic [ROW_W-1:0]             used_ff, used_in;
   logic [SYM_W-1:0]             sym_ff, sym_in;
   logic [MAX_ORDER-1:0]         found_ff, found_in;
   logic [MAX_ORDER-1:0][CTX_IW-1:0] fidx_ff, fidx_in;
   logic [ORD_W-1:0]             ord_ff, ord_in;
   logic [ROW_W-1:0]             idx_ff, idx_in;
   logic                         pend_ff, pend_in;
   logic [SYM_W-1:0]             pidx_ff, pidx_in;
   logic [ROW_W-1:0]             row_ff, row_in;
   logic [TOT_W-1:0]             cum_ff, cum_in;
   logic [CNT_W-1:0]             freq_ff, freq_in;
   logic [TOT_W-1:0]             dtot_ff, dtot_in;
   logic                         coded_ff, coded_in;
   logic [ORD_W-1:0]             k_ff, k_in;
   logic [RNG_W-1:0]             q_ff, q_in;

   logic                         div_start, div_done;
   logic [RNG_W-1:0]             div_quot;
   logic                         out_load, out_last, out_free;
   logic [7:0]                   out_byte;

   logic [MAX_ORDER-1:0][KEY_W-1:0] keys;
   logic [KEY_W-1:0]             cur_key;
   logic [ORD_W-1:0]             ord_m1;
   logic [ORD_IW-1:0]            oi;
   logic [TOT_W-1:0]             rd_tot;
   logic [CNT_W-1:0]             base_val;
   logic [CNT_W-1:0]             sum_val;
   logic [RNG_W-1:0]             low_sum;
   logic [55:0]                  prod_low;
   logic [47:0]                  prod_rng;

   always_comb begin
      for (int o = 0; o < MAX_ORDER; o++) begin
         keys[o] = ctx_key(ORD_W'(o + 1), hist_ff);
      end
   end

   assign cur_key  = ctx_key(ord_ff, hist_ff);
   assign ord_m1   = ord_ff - ORD_W'(1);
   assign oi       = ord_m1[ORD_IW-1:0];
   assign rd_tot   = ctx_rd_ff[TOT_W-1:0];
   assign base_val = base_vld_ff[sym_ff] ? cnt_rd_ff : CNT_W'(1);
   assign sum_val  = (row_ff == BASE_ROW && !base_vld_ff[pidx_ff]) ? CNT_W'(1) : cnt_rd_ff;
   assign low_sum  = low_ff + range_ff;
   assign prod_low = {8'h0, cum_ff} * {24'h0, q_ff};
   assign prod_rng = {16'h0, q_ff} * {32'h0, freq_ff};
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      low_in      = low_ff;
      range_in    = range_ff;
      hist_in     = hist_ff;
      seen_in     = seen_ff;
      base_vld_in = base_vld_ff;
      base_tot_in = base_tot_ff;
      used_in     = used_ff;
      sym_in      = sym_ff;
      found_in    = found_ff;
      fidx_in     = fidx_ff;
      ord_in      = ord_ff;
      idx_in      = idx_ff;
      pend_in     = pend_ff;
      pidx_in     = pidx_ff;
      row_in      = row_ff;
      cum_in      = cum_ff;
      freq_in     = freq_ff;
      dtot_in     = dtot_ff;
      coded_in    = coded_ff;
      k_in        = k_ff;
      q_in        = q_ff;
      cnt_we      = 1'b0;
      cnt_waddr   = '0;
      cnt_wdata   = '0;
      cnt_raddr   = '0;
      ctx_we      = 1'b0;
      ctx_waddr   = '0;
      ctx_wdata   = '0;
      ctx_raddr   = '0;
      div_start   = 1'b0;
      out_load    = 1'b0;
      out_byte    = low_ff[31:24];
      out_last    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               k_in = '0;
               if (req_command == CMD_FINISH) begin
                  state_in = ST_FLUSH;
               end else begin
                  sym_in   = req_symbol;
                  found_in = '0;
                  idx_in   = '0;
                  pend_in  = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_FLUSH: begin
            // Four bytes of low, most significant first; the last resets all.
            if (out_free) begin
               out_load = 1'b1;
               out_last = (k_ff == ORD_W'(3));
               low_in   = {low_ff[23:0], 8'h0};
               k_in     = k_ff + ORD_W'(1);
               if (k_ff == ORD_W'(3)) begin
                  low_in      = '0;
                  range_in    = '1;
                  hist_in     = '0;
                  seen_in     = '0;
                  base_vld_in = '0;
                  base_tot_in = BASE_INIT;
                  used_in     = '0;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            // Stored keys are distinct, so at most one match per order.
            pend_in = 1'b0;
            if (idx_ff < used_ff) begin
               ctx_raddr = idx_ff[CTX_IW-1:0];
               pend_in   = 1'b1;
               pidx_in   = idx_ff[CTX_IW-1:0];
               idx_in    = idx_ff + ROW_W'(1);
            end
            if (pend_ff) begin
               for (int o = 0; o < MAX_ORDER; o++) begin
                  if (ctx_rd_ff[CTX_DW-1:TOT_W] == keys[o]) begin
                     found_in[o] = 1'b1;
                     fidx_in[o]  = pidx_ff;
                  end
               end
            end
            if (idx_ff >= used_ff && !pend_ff) begin
               ord_in   = ORD_W'(MAX_ORDER);
               state_in = ST_ORD_CHK;
            end
         end
         ST_ORD_CHK: begin
            if (ord_ff == '0) begin
               cnt_raddr = {BASE_ROW, sym_ff};
               state_in  = ST_BASE_RD;
            end else if (found_ff[oi]) begin
               cnt_raddr = {1'b0, fidx_ff[oi], sym_ff};
               ctx_raddr = fidx_ff[oi];
               state_in  = ST_ORD_RD;
            end else begin
               ord_in = ord_m1;
            end
         end
         ST_ORD_RD: begin
            dtot_in = rd_tot + TOT_W'(1);
            cum_in  = '0;
            idx_in  = '0;
            pend_in = 1'b0;
            if (cnt_rd_ff == '0) begin
               // Escape: code the top slot of this context.
               cum_in   = rd_tot;
               freq_in  = CNT_W'(1);
               coded_in = 1'b0;
               state_in = ST_DIV_GO;
            end else begin
               freq_in  = cnt_rd_ff;
               coded_in = 1'b1;
               row_in   = {1'b0, fidx_ff[oi]};
               state_in = ST_SUM;
            end
         end
         ST_BASE_RD: begin
            freq_in  = base_val;
            dtot_in  = base_tot_ff;
            coded_in = 1'b1;
            row_in   = BASE_ROW;
            cum_in   = '0;
            idx_in   = '0;
            pend_in  = 1'b0;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            pend_in = 1'b0;
            if (idx_ff < {1'b0, sym_ff}) begin
               cnt_raddr = {row_ff, idx_ff[SYM_W-1:0]};
               pend_in   = 1'b1;
               pidx_in   = idx_ff[SYM_W-1:0];
               idx_in    = idx_ff + ROW_W'(1);
            end
            if (pend_ff) begin
               cum_in = cum_ff + TOT_W'(sum_val);
            end
            if (idx_ff >= {1'b0, sym_ff} && !pend_ff) begin
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               q_in     = div_quot;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            low_in   = low_ff + prod_low[RNG_W-1:0];
            range_in = prod_rng[RNG_W-1:0];
            k_in     = '0;
            state_in = ST_REN1;
         end
         ST_REN1: begin
            // Shift out settled top bytes, at most four.
            if (k_ff == ORD_W'(4) || (low_ff[31:24] ^ low_sum[31:24]) != 8'h0) begin
               k_in     = '0;
               state_in = ST_REN2;
            end else if (out_free) begin
               out_load = 1'b1;
               low_in   = {low_ff[23:0], 8'h0};
               range_in = {range_ff[23:0], 8'h0};
               k_in     = k_ff + ORD_W'(1);
            end
         end
         ST_REN2: begin
            // Underflow: force out a byte and widen the range, at most three times.
            if (k_ff == ORD_W'(3) || range_ff[31:16] != 16'h0) begin
               if (coded_ff) begin
                  state_in = ST_UPD_BASE_RD;
               end else begin
                  ord_in   = ord_m1;
                  state_in = ST_ORD_CHK;
               end
            end else if (out_free) begin
               out_load = 1'b1;
               range_in = {~low_ff[23:0], 8'h0};
               low_in   = {low_ff[23:0], 8'h0};
               k_in     = k_ff + ORD_W'(1);
            end
         end
         ST_UPD_BASE_RD: begin
            cnt_raddr = {BASE_ROW, sym_ff};
            state_in  = ST_UPD_BASE_WR;
         end
         ST_UPD_BASE_WR: begin
            if (base_val != CNT_MAX) begin
               cnt_we              = 1'b1;
               cnt_waddr           = {BASE_ROW, sym_ff};
               cnt_wdata           = base_val + CNT_W'(1);
               base_vld_in[sym_ff] = 1'b1;
               base_tot_in         = base_tot_ff + TOT_W'(1);
            end
            ord_in   = ORD_W'(1);
            state_in = ST_UPD_ORD;
         end
         ST_UPD_ORD: begin
            if (ord_ff > ORD_W'(MAX_ORDER) || seen_ff < ord_m1) begin
               state_in = ST_FIN;
            end else if (found_ff[oi]) begin
               cnt_raddr = {1'b0, fidx_ff[oi], sym_ff};
               ctx_raddr = fidx_ff[oi];
               state_in  = ST_UPD_WR;
            end else if (used_ff < ROW_W'(CTX_ENTRIES)) begin
               // New entry: key and a total of one; its row is cleared next.
               ctx_we    = 1'b1;
               ctx_waddr = used_ff[CTX_IW-1:0];
               ctx_wdata = {cur_key, TOT_W'(1)};
               row_in    = used_ff;
               used_in   = used_ff + ROW_W'(1);
               idx_in    = '0;
               state_in  = ST_CLR;
            end else begin
               ord_in = ord_ff + ORD_W'(1);
            end
         end
         ST_UPD_WR: begin
            if (cnt_rd_ff != CNT_MAX) begin
               cnt_we    = 1'b1;
               cnt_waddr = {1'b0, fidx_ff[oi], sym_ff};
               cnt_wdata = cnt_rd_ff + CNT_W'(1);
               ctx_we    = 1'b1;
               ctx_waddr = fidx_ff[oi];
               ctx_wdata = {cur_key, rd_tot + TOT_W'(1)};
            end
            ord_in   = ord_ff + ORD_W'(1);
            state_in = ST_UPD_ORD;
         end
         ST_CLR: begin
            cnt_we    = 1'b1;
            cnt_waddr = {row_ff, idx_ff[SYM_W-1:0]};
            cnt_wdata = (idx_ff[SYM_W-1:0] == sym_ff) ? CNT_W'(1) : CNT_W'(0);
            idx_in    = idx_ff + ROW_W'(1);
            if (idx_ff[SYM_W-1:0] == 8'hFF) begin
               ord_in   = ord_ff + ORD_W'(1);
               state_in = ST_UPD_ORD;
            end
         end
         ST_FIN: begin
            hist_in = {hist_ff[23:0], sym_ff};
            if (seen_ff < ORD_W'(MAX_ORDER)) begin
               seen_in = seen_ff + ORD_W'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         low_ff      <= '0;
         range_ff    <= '1;
         hist_ff     <= '0;
         seen_ff     <= '0;
         base_vld_ff <= '0;
         base_tot_ff <= BASE_INIT;
         used_ff     <= '0;
         pend_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         low_ff      <= low_in;
         range_ff    <= range_in;
         hist_ff     <= hist_in;
         seen_ff     <= seen_in;
         base_vld_ff <= base_vld_in;
         base_tot_ff <= base_tot_in;
         used_ff     <= used_in;
         pend_ff     <= pend_in;
      end
      sym_ff   <= sym_in;
      found_ff <= found_in;
      fidx_ff  <= fidx_in;
      ord_ff   <= ord_in;
      idx_ff   <= idx_in;
      pidx_ff  <= pidx_in;
      row_ff   <= row_in;
      cum_ff   <= cum_in;
      freq_ff  <= freq_in;
      dtot_ff  <= dtot_in;
      coded_ff <= coded_in;
      k_ff     <= k_in;
      q_ff     <= q_in;
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctx_we) begin
         ctx_mem[ctx_waddr] <= ctx_wdata;
      end
      ctx_rd_ff <= ctx_mem[ctx_raddr];
   end

   ppmre_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (range_ff),
      .divisor  (dtot_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   ppmre_out u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (out_load),
      .load_byte    (out_byte),
      .load_last    (out_last),
      .free         (out_free),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// PPM range encoder testbench
// Streams of encode transactions, each ended by a finish, are driven through
// a valid/ready channel with random idling. Every compressed byte that comes
// back is checked against a behavioural model of the context tables and the
// range coder.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ppmre_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES    = 600;

   typedef struct {
      command_type cmd;
      logic [7:0]  sym;
   } cmd_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_command = CMD_ENCODE;
   logic [7:0] req_symbol = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;

   ppm_range_encoder_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_symbol   (req_symbol),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   // Commands waiting to be offered, and the compressed bytes still owed.
   cmd_item_type pending_cmds[$];
   logic [7:0]   owed_bytes[$];
   logic         owed_last[$];

   int errors       = 0;
   int cmds_taken   = 0;
   int bytes_taken  = 0;
   int finishes     = 0;
   int peak_entries = 0;
   int quiet_cycles = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   // ---------------------------------------------------------------------
   // Compressor model: its own copy of the coder registers and the tables.
   // ---------------------------------------------------------------------
   bit [31:0]   m_low;
   bit [31:0]   m_range;
   bit [7:0]    m_hist[4];
   int          m_seen;
   bit [15:0]   m_base_cnt[256];
   int unsigned m_base_tot;
   bit [34:0]   m_key[CTX_ENTRIES];
   bit          m_key_ok[CTX_ENTRIES];
   bit [15:0]   m_ctx_cnt[CTX_ENTRIES][256];
   int unsigned m_ctx_tot[CTX_ENTRIES];
   int          m_used;

   function automatic void model_clear();
      m_low   = '0;
      m_range = '1;
      m_seen  = 0;
      m_base_tot = 256;
      m_used  = 0;
      foreach (m_hist[i]) m_hist[i] = '0;
      foreach (m_base_cnt[i]) m_base_cnt[i] = 16'd1;
      foreach (m_key_ok[i]) m_key_ok[i] = 1'b0;
   endfunction

   function automatic void owe_byte(bit [7:0] b, bit lst);
      owed_bytes = {owed_bytes, b};
      owed_last  = {owed_last, lst};
   endfunction

   // One interval through the range coder, with both renormalising loops.
   function automatic void narrow_interval(bit [31:0] cum, bit [31:0] freq,
                                           bit [31:0] total);
      bit [31:0] upper;
      if (total == 0) total = 1;
      m_range = m_range / total;
      m_low   = m_low + cum * m_range;
      m_range = m_range * freq;
      for (int k = 0; k < 4; k++) begin
         upper = m_low + m_range;
         if ((m_low ^ upper) >= 32'h0100_0000) break;
         owe_byte(m_low[31:24], 1'b0);
         m_low   = m_low << 8;
         m_range = m_range << 8;
      end
      for (int k = 0; k < 3; k++) begin
         if (m_range >= 32'h0001_0000) break;
         owe_byte(m_low[31:24], 1'b0);
         m_range = (~m_low) << 8;
         m_low   = m_low << 8;
      end
   endfunction

   function automatic bit [34:0] order_key(int ord);
      bit [34:0] k;
      k = {3'(ord), 32'h0};
      for (int i = 0; i < ord; i++) k[8*i +: 8] = m_hist[i];
      return k;
   endfunction

   function automatic int lookup_ctx(bit [34:0] k);
      for (int e = 0; e < m_used; e++)
         if (m_key_ok[e] && m_key[e] == k) return e;
      return -1;
   endfunction

   function automatic void predict_bytes(cmd_item_type it);
      bit        done;
      int        e;
      bit [31:0] cum;
      done = 1'b0;
      if (it.cmd == CMD_FINISH) begin
         for (int j = 3; j >= 0; j--) owe_byte(m_low[8*j +: 8], j == 0);
         model_clear();
         return;
      end
      // Highest order first; an absent context is skipped, a zero count escapes.
      for (int ord = MAX_ORDER; ord >= 1 && !done; ord--) begin
         e = lookup_ctx(order_key(ord));
         if (e >= 0) begin
            if (m_ctx_cnt[e][it.sym] == 0) begin
               narrow_interval(m_ctx_tot[e], 1, m_ctx_tot[e] + 1);
            end else begin
               cum = 0;
               for (int s = 0; s < it.sym; s++) cum += m_ctx_cnt[e][s];
               narrow_interval(cum, m_ctx_cnt[e][it.sym], m_ctx_tot[e] + 1);
               done = 1'b1;
            end
         end
      end
      if (!done) begin
         cum = 0;
         for (int s = 0; s < it.sym; s++) cum += m_base_cnt[s];
         narrow_interval(cum, m_base_cnt[it.sym], m_base_tot);
      end
      // Model update; counts saturate and the table stops growing when full.
      if (m_base_cnt[it.sym] != CNT_MAX) begin
         m_base_cnt[it.sym]++;
         m_base_tot++;
      end
      for (int ord = 1; ord <= MAX_ORDER; ord++) begin
         bit [34:0] k;
         if (m_seen < ord - 1) break;
         k = order_key(ord);
         e = lookup_ctx(k);
         if (e < 0 && m_used < CTX_ENTRIES) begin
            e = m_used;
            m_used++;
            m_key_ok[e] = 1'b1;
            m_key[e]    = k;
            m_ctx_tot[e] = 0;
            for (int s = 0; s < 256; s++) m_ctx_cnt[e][s] = '0;
         end
         if (e >= 0 && m_ctx_cnt[e][it.sym] != CNT_MAX) begin
            m_ctx_cnt[e][it.sym]++;
            m_ctx_tot[e]++;
         end
      end
      for (int j = MAX_ORDER - 1; j > 0; j--) m_hist[j] = m_hist[j-1];
      m_hist[0] = it.sym;
      if (m_seen < MAX_ORDER) m_seen++;
      if (m_used > peak_entries) peak_entries = m_used;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   function automatic void queue_cmd(command_type c, logic [7:0] s);
      cmd_item_type it;
      it.cmd = c;
      it.sym = s;
      pending_cmds = {pending_cmds, it};
   endfunction

   // A stream of encodes drawn from an alphabet of the given size, then a
   // finish. Small alphabets give repeated contexts and so nonzero counts.
   function automatic void queue_stream(int len, int alpha);
      logic [7:0] offs;
      offs = 8'($urandom);
      for (int i = 0; i < len; i++)
         queue_cmd(CMD_ENCODE, offs + 8'($urandom_range(alpha - 1)));
      queue_cmd(CMD_FINISH, 8'($urandom));
   endfunction

   // The quiet window: no idling on either side while it lasts.
   function automatic bit busy_window();
      return cmds_taken >= 150 && cmds_taken < 200;
   endfunction

   // ---------------------------------------------------------------------
   // Clock and reset.
   // ---------------------------------------------------------------------
   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Driver: offers the next pending command; the model is run at the edge
   // at which a transaction is accepted, using the payload then on the port.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cmd_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            it.cmd = command_type'(req_command);
            it.sym = req_symbol;
            predict_bytes(it);
            cmds_taken++;
            if (it.cmd == CMD_FINISH) finishes++;
         end
         if (pending_cmds.size() > 0 && (busy_window() || $urandom_range(99) >= 26)) begin
            it = pending_cmds.pop_front();
            req_command <= it.cmd;
            req_symbol  <= it.sym;
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off so that the encoder
   // backs up and stops taking commands while the driver keeps offering.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && cmds_taken >= 100) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= busy_window() || $urandom_range(99) >= 26;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: each compressed byte is compared with the oldest one owed.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      logic [7:0] want_byte;
      logic       want_last;
      if (!reset && rsp_valid && rsp_ready) begin
         bytes_taken++;
         if (owed_bytes.size() == 0) begin
            $error("unexpected transaction: out_byte %0h last %0b", rsp_out_byte,
                   rsp_last);
            errors++;
         end else begin
            want_byte = owed_bytes.pop_front();
            want_last = owed_last.pop_front();
            if (rsp_out_byte !== want_byte) begin
               $error("out_byte: expected %0h, got %0h", want_byte, rsp_out_byte);
               errors++;
            end
            if (rsp_last !== want_last) begin
               $error("last: expected %0b, got %0b", want_last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Watchdog: a run in which nothing moves for too long is stuck.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ppm_range_encoder_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------
   initial begin
      model_clear();

      // Directed part: a finish straight after reset, the extreme symbols,
      // a repeating pattern so that higher orders both escape and code the
      // symbol, and two finishes back to back.
      queue_cmd(CMD_FINISH, 8'h00);
      queue_cmd(CMD_ENCODE, 8'h00);
      queue_cmd(CMD_ENCODE, 8'hFF);
      queue_cmd(CMD_ENCODE, 8'h80);
      queue_cmd(CMD_ENCODE, 8'h7F);
      for (int i = 0; i < 12; i++) queue_cmd(CMD_ENCODE, (i % 3 == 0) ? 8'h41 : 8'h42);
      queue_cmd(CMD_ENCODE, 8'h55);
      queue_cmd(CMD_ENCODE, 8'hAA);
      queue_cmd(CMD_FINISH, 8'hFF);
      queue_cmd(CMD_FINISH, 8'h00);

      // Random part: short streams over small alphabets, one over the whole byte
      // range, one long varied stream that fills the table, and a few over random alphabets.
      for (int i = 0; i < 8; i++) queue_stream($urandom_range(2, 14), $urandom_range(2, 6));
      queue_stream(8, 256);
      queue_stream(150, 24);
      for (int i = 0; i < 5; i++) queue_stream($urandom_range(3, 10), $urandom_range(2, 256));

      wait (!reset);
      wait (pending_cmds.size() == 0 && !req_valid && owed_bytes.size() == 0);
      repeat (100) @(posedge clock);
      if (owed_bytes.size() != 0) begin
         $error("%0d compressed bytes never arrived", owed_bytes.size());
         errors++;
      end

      $display("Covered %0d commands (%0d finishes) and %0d compressed bytes;",
               cmds_taken, finishes, bytes_taken);
      $display("the context table reached %0d of %0d entries.", peak_entries,
               CTX_ENTRIES);
      if (errors == 0) begin
         $display("ppm_range_encoder_top verification clean");
      end else begin
         $display("ppm_range_encoder_top verification failed");
      end
      $finish;
   end

endmodule
